// ----- src/assert_macros.svh -----
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check a condition at every clock edge outside reset
`define SPMA_CHECK(name, cond, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// check that a condition implies another in the next cycle
`define SPMA_CHECK_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- src/spma_pkg.sv -----
package spma_pkg;

	localparam int MAX_TERMS = 32;
	localparam int CNT_W = $clog2(MAX_TERMS + 1);
	localparam int ADDR_W = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

	localparam logic [1:0] CMD_LOAD_FIRST = 2'd0;
	localparam logic [1:0] CMD_LOAD_SECOND = 2'd1;
	localparam logic [1:0] CMD_RUN = 2'd2;

	localparam logic signed [31:0] COEF_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] COEF_MIN = 32'sh8000_0000;

	typedef struct packed {
		logic [1:0] command;
		logic signed [31:0] coefficient;
		logic [15:0] exponent;
	} in_word_t;

	typedef struct packed {
		logic signed [31:0] sum_coefficient;
		logic [15:0] sum_exponent;
		logic last_term;
		logic empty_sum;
		logic load_overflow;
	} out_word_t;

	typedef enum logic [1:0] {
		OP_LOAD_FIRST,
		OP_LOAD_SECOND,
		OP_RUN
	} op_t;

	typedef struct packed {
		logic signed [31:0] coef;
		logic [15:0] expn;
	} term_t;

	typedef struct packed {
		op_t op;
		term_t term;
	} job_t;

	function automatic logic signed [31:0] sat_add(logic signed [31:0] a, logic signed [31:0] b);
		logic signed [32:0] s;
		s = {a[31], a} + {b[31], b};
		if (s[32] != s[31]) begin
			sat_add = s[32] ? COEF_MIN : COEF_MAX;
		end else begin
			sat_add = s[31:0];
		end
	endfunction

endpackage

// ----- src/spma_cmd_queue.sv -----
module spma_cmd_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  spma_pkg::in_word_t in_data,
	output logic              job_valid,
	input  logic              job_pop,
	output spma_pkg::job_t    job
);
	import spma_pkg::*;

	job_t             slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;
	logic             accept;
	logic             keep;
	logic             pop;
	job_t             job_in;

	assign in_ready = (cnt_q != QCNT_W'(QUEUE_DEPTH));
	assign accept = in_valid && in_ready;
	assign job_valid = (cnt_q != '0);
	assign pop = job_pop && job_valid;
	assign job = slot_q[rd_ptr_q];

	// classify; drop the unused command
	always_comb begin
		job_in.term.coef = in_data.coefficient;
		job_in.term.expn = in_data.exponent;
		job_in.op = OP_RUN;
		keep = 1'b1;
		unique case (in_data.command)
			CMD_LOAD_FIRST: job_in.op = OP_LOAD_FIRST;
			CMD_LOAD_SECOND: job_in.op = OP_LOAD_SECOND;
			CMD_RUN: job_in.op = OP_RUN;
			default: keep = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (accept && keep) begin
			slot_q[wr_ptr_q] <= job_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (accept && keep) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			cnt_q <= cnt_q + QCNT_W'(accept && keep) - QCNT_W'(pop);
		end
	end

endmodule

// ----- src/spma_merge.sv -----
module spma_merge (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                job_valid,
	output logic                job_pop,
	input  spma_pkg::job_t      job,
	output logic                out_valid,
	input  logic                out_ready,
	output spma_pkg::out_word_t out_data
);
	import spma_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE  = 2'b01,
		ST_MERGE = 2'b10
	} state_t;

	state_t           state_q;
	logic [CNT_W-1:0] cnt_a_q;
	logic [CNT_W-1:0] cnt_b_q;
	logic [CNT_W-1:0] i_q;
	logic [CNT_W-1:0] j_q;
	logic [CNT_W-1:0] i_nxt;
	logic [CNT_W-1:0] j_nxt;
	logic             ovf_q;
	term_t            mem_a_q [MAX_TERMS];
	term_t            mem_b_q [MAX_TERMS];
	term_t            rd_a_q;
	term_t            rd_b_q;
	term_t            pend_q;
	logic             pend_valid_q;
	out_word_t        out_q;
	logic             out_valid_q;

	logic             a_left;
	logic             b_left;
	logic             out_free;
	logic             step;
	logic             finish;
	logic             load_a;
	logic             load_b;
	logic             new_valid;
	term_t            new_term;
	logic signed [31:0] pair_sum;

	assign out_valid = out_valid_q;
	assign out_data = out_q;

	assign a_left = (i_q < cnt_a_q);
	assign b_left = (j_q < cnt_b_q);
	assign out_free = !out_valid_q || out_ready;
	assign job_pop = (state_q == ST_IDLE);
	assign load_a = job_pop && job_valid && (job.op == OP_LOAD_FIRST)
		&& (cnt_a_q < CNT_W'(MAX_TERMS));
	assign load_b = job_pop && job_valid && (job.op == OP_LOAD_SECOND)
		&& (cnt_b_q < CNT_W'(MAX_TERMS));
	assign step = (state_q == ST_MERGE) && out_free && (a_left || b_left);
	assign finish = (state_q == ST_MERGE) && out_free && !a_left && !b_left;
	assign pair_sum = sat_add(rd_a_q.coef, rd_b_q.coef);

	always_comb begin
		i_nxt = i_q;
		j_nxt = j_q;
		new_valid = 1'b0;
		new_term = rd_a_q;
		if (step) begin
			if (!b_left || (a_left && rd_a_q.expn < rd_b_q.expn)) begin
				new_valid = 1'b1;
				new_term = rd_a_q;
				i_nxt = i_q + 1'b1;
			end else if (!a_left || rd_a_q.expn > rd_b_q.expn) begin
				new_valid = 1'b1;
				new_term = rd_b_q;
				j_nxt = j_q + 1'b1;
			end else begin
				new_valid = (pair_sum != '0);
				new_term.coef = pair_sum;
				new_term.expn = rd_a_q.expn;
				i_nxt = i_q + 1'b1;
				j_nxt = j_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_a) begin
			mem_a_q[cnt_a_q[ADDR_W-1:0]] <= job.term;
		end
		if (load_b) begin
			mem_b_q[cnt_b_q[ADDR_W-1:0]] <= job.term;
		end
		rd_a_q <= mem_a_q[i_nxt[ADDR_W-1:0]];
		rd_b_q <= mem_b_q[j_nxt[ADDR_W-1:0]];
	end

	always_ff @(posedge clk) begin
		if (step && new_valid) begin
			pend_q <= new_term;
		end
		if (step && new_valid && pend_valid_q) begin
			out_q.sum_coefficient <= pend_q.coef;
			out_q.sum_exponent <= pend_q.expn;
			out_q.last_term <= 1'b0;
			out_q.empty_sum <= 1'b0;
			out_q.load_overflow <= ovf_q;
		end else if (finish) begin
			out_q.sum_coefficient <= pend_valid_q ? pend_q.coef : '0;
			out_q.sum_exponent <= pend_valid_q ? pend_q.expn : '0;
			out_q.last_term <= 1'b1;
			out_q.empty_sum <= !pend_valid_q;
			out_q.load_overflow <= ovf_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_a_q <= '0;
			cnt_b_q <= '0;
			i_q <= '0;
			j_q <= '0;
			ovf_q <= 1'b0;
			pend_valid_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			i_q <= i_nxt;
			j_q <= j_nxt;
			if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (job_valid) begin
						unique case (job.op)
							OP_LOAD_FIRST: begin
								if (load_a) begin
									cnt_a_q <= cnt_a_q + 1'b1;
								end else begin
									ovf_q <= 1'b1;
								end
							end
							OP_LOAD_SECOND: begin
								if (load_b) begin
									cnt_b_q <= cnt_b_q + 1'b1;
								end else begin
									ovf_q <= 1'b1;
								end
							end
							default: state_q <= ST_MERGE;
						endcase
					end
				end
				ST_MERGE: begin
					if (step && new_valid) begin
						pend_valid_q <= 1'b1;
						if (pend_valid_q) begin
							out_valid_q <= 1'b1;
						end
					end
					if (finish) begin
						out_valid_q <= 1'b1;
						pend_valid_q <= 1'b0;
						cnt_a_q <= '0;
						cnt_b_q <= '0;
						i_q <= '0;
						j_q <= '0;
						ovf_q <= 1'b0;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// ----- src/sparse_polynomial_merge_add.sv -----
// Load words: one per cycle, queued four deep; hold input once four wait behind a merge.
// Add word: the merge starts once the word leaves the queue and retires one term or
// matched pair per cycle while the output is free, through the single read port of each
// term memory; result words leave at most one per cycle. Reset clears the queue, counts,
// overflow flag and valid flags; term memories keep their contents and are only used
// below counts.
`include "assert_macros.svh"

module sparse_polynomial_merge_add (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  spma_pkg::in_word_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output spma_pkg::out_word_t out_data
);
	import spma_pkg::*;

	logic job_valid;
	logic job_pop;
	job_t job;

	spma_cmd_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.job_valid(job_valid),
		.job_pop  (job_pop),
		.job      (job)
	);

	spma_merge u_merge (
		.clk      (clk),
		.arst_n   (arst_n),
		.job_valid(job_valid),
		.job_pop  (job_pop),
		.job      (job),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

	`SPMA_CHECK(a_empty_is_last,
		!out_valid || !out_data.empty_sum || out_data.last_term,
		"empty word not marked last")
	`SPMA_CHECK(a_empty_no_term,
		!out_valid || !out_data.empty_sum
		|| (out_data.sum_coefficient == '0 && out_data.sum_exponent == '0),
		"empty word carries a term")
	`SPMA_CHECK_NEXT(a_ovf_steady,
		out_valid && out_ready && !out_data.last_term,
		!out_valid || out_data.load_overflow == $past(out_data.load_overflow),
		"overflow flag changed inside a run")

endmodule

// ----- bench/merge_add_checker.sv -----
`timescale 1ns / 1ps

module merge_add_checker (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                in_ready,
	input  spma_pkg::in_word_t  in_data,
	input  logic                out_valid,
	input  logic                out_ready,
	input  spma_pkg::out_word_t out_data,
	output int                  mismatches,
	output int                  pending,
	output int                  checked
);
	import spma_pkg::*;

	term_t first_terms[MAX_TERMS];
	term_t second_terms[MAX_TERMS];
	int first_len;
	int second_len;
	logic lost_terms;
	out_word_t expected_sums[$];
	int fail_count;
	int seen_count;

	function automatic logic signed [31:0] clamp_sum(logic signed [31:0] a, logic signed [31:0] b);
		longint s;
		s = longint'(a) + longint'(b);
		if (s > longint'(COEF_MAX))
			return COEF_MAX;
		if (s < longint'(COEF_MIN))
			return COEF_MIN;
		return s[31:0];
	endfunction

	task automatic push_sum(logic signed [31:0] coef, logic [15:0] expn, logic empty);
		out_word_t w;
		w.sum_coefficient = coef;
		w.sum_exponent = expn;
		w.last_term = 1'b0;
		w.empty_sum = empty;
		w.load_overflow = lost_terms;
		expected_sums.push_back(w);
	endtask

	task automatic merge_terms();
		int i;
		int j;
		int base;
		logic signed [31:0] s;
		out_word_t w;
		i = 0;
		j = 0;
		base = expected_sums.size();
		while (i < first_len || j < second_len) begin
			if (j >= second_len ||
					(i < first_len && first_terms[i].expn < second_terms[j].expn)) begin
				push_sum(first_terms[i].coef, first_terms[i].expn, 1'b0);
				i++;
			end else if (i >= first_len || first_terms[i].expn > second_terms[j].expn) begin
				push_sum(second_terms[j].coef, second_terms[j].expn, 1'b0);
				j++;
			end else begin
				s = clamp_sum(first_terms[i].coef, second_terms[j].coef);
				if (s != 0)
					push_sum(s, first_terms[i].expn, 1'b0);
				i++;
				j++;
			end
		end
		if (expected_sums.size() == base)
			push_sum('0, '0, 1'b1);
		w = expected_sums.pop_back();
		w.last_term = 1'b1;
		expected_sums.push_back(w);
		first_len = 0;
		second_len = 0;
		lost_terms = 1'b0;
	endtask

	always @(posedge clk or negedge arst_n) begin
		out_word_t want;
		term_t t;
		if (!arst_n) begin
			first_len = 0;
			second_len = 0;
			lost_terms = 1'b0;
			expected_sums.delete();
			fail_count = 0;
			seen_count = 0;
			mismatches <= 0;
			pending <= 0;
			checked <= 0;
		end else begin
			if (out_valid && out_ready) begin
				seen_count++;
				if (expected_sums.size() == 0) begin
					if (fail_count < 10)
						$display("unexpected word: coef %h exp %h last %b empty %b ovf %b",
							out_data.sum_coefficient, out_data.sum_exponent,
							out_data.last_term, out_data.empty_sum, out_data.load_overflow);
					fail_count++;
				end else begin
					want = expected_sums.pop_front();
					if (want !== out_data) begin
						if (fail_count < 10) begin
							$display("mismatch: want coef %h exp %h last %b empty %b ovf %b",
								want.sum_coefficient, want.sum_exponent, want.last_term,
								want.empty_sum, want.load_overflow);
							$display("          got  coef %h exp %h last %b empty %b ovf %b",
								out_data.sum_coefficient, out_data.sum_exponent,
								out_data.last_term, out_data.empty_sum, out_data.load_overflow);
						end
						fail_count++;
					end
				end
			end
			if (in_valid && in_ready) begin
				t.coef = in_data.coefficient;
				t.expn = in_data.exponent;
				case (in_data.command)
					CMD_LOAD_FIRST: begin
						if (first_len < MAX_TERMS) begin
							first_terms[first_len] = t;
							first_len++;
						end else begin
							lost_terms = 1'b1;
						end
					end
					CMD_LOAD_SECOND: begin
						if (second_len < MAX_TERMS) begin
							second_terms[second_len] = t;
							second_len++;
						end else begin
							lost_terms = 1'b1;
						end
					end
					CMD_RUN: begin
						merge_terms();
					end
					default: begin
					end
				endcase
			end
			mismatches <= fail_count;
			pending <= expected_sums.size();
			checked <= seen_count;
		end
	end

endmodule

// ----- bench/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
	import spma_pkg::*;

	localparam logic [1:0] CMD_SPARE = 2'd3;
	localparam int STALL_LIMIT = 2000;
	localparam int DRAIN_CYCLES = 100;
	localparam int PHASE_ITEMS = 135;

	localparam int SEQ_FULL = 0;
	localparam int SEQ_OVERFLOW = 1;
	localparam int SEQ_UNSORTED = 2;
	localparam int SEQ_NO_RUN = 3;
	localparam int SEQ_KINDS = 20;

	logic clk;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	in_word_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	out_word_t out_data;

	int send_idle_pct = 20;
	int recv_idle_pct = 73;
	int mismatches;
	int pending;
	int checked;
	int sent_items = 0;
	int runs = 0;
	int stall_cycles = 0;

	sparse_polynomial_merge_add u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

	merge_add_checker u_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.mismatches(mismatches),
		.pending   (pending),
		.checked   (checked)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready)) begin
				stall_cycles <= 0;
			end else if (stall_cycles >= STALL_LIMIT) begin
				$display("tb: failure");
				$finish;
			end else begin
				stall_cycles <= stall_cycles + 1;
			end
		end
	end

	task automatic send_word(input in_word_t w);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= w;
		do @(posedge clk); while (!in_ready);
		if (w.command != CMD_SPARE)
			sent_items++;
		if (w.command == CMD_RUN)
			runs++;
	endtask

	task automatic put_word(input logic [1:0] cmd, input logic signed [31:0] coef,
			input logic [15:0] expn);
		in_word_t w;
		w.command = cmd;
		w.coefficient = coef;
		w.exponent = expn;
		send_word(w);
	endtask

	// hold the sender until every expected word has come back
	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	function automatic logic signed [31:0] random_coef();
		int v;
		case ($urandom_range(0, 9))
			0: return '0;
			1: return COEF_MAX;
			2: return COEF_MIN;
			3: begin
				v = $urandom_range(0, 8191);
				return (v - 4096) * 65536;
			end
			default: return $urandom;
		endcase
	endfunction

	task automatic send_polynomials(input int kind);
		in_word_t first_q[$];
		in_word_t second_q[$];
		in_word_t w;
		int n_cand;
		int step_max;
		int e;
		int route;
		int k;
		int pos;
		int pick;
		logic signed [31:0] a;
		logic signed [31:0] b;
		if (kind == SEQ_FULL)
			n_cand = 2 * MAX_TERMS;
		else if (kind == SEQ_OVERFLOW)
			n_cand = $urandom_range(MAX_TERMS + 1, MAX_TERMS + 6);
		else
			n_cand = $urandom_range(0, 8);
		case ($urandom_range(0, 3))
			0: step_max = 1;
			1: step_max = 4;
			default: step_max = 65535 / (n_cand + 1);
		endcase
		e = 65535 - n_cand * step_max;
		if ($urandom_range(0, 1))
			e = $urandom_range(0, e);
		for (k = 0; k < n_cand; k++) begin
			e += (k == 0) ? $urandom_range(0, step_max - 1) : $urandom_range(1, step_max);
			if (kind == SEQ_FULL)
				route = k % 2;
			else if (kind == SEQ_OVERFLOW && $urandom_range(0, 3) != 0)
				route = 2;
			else
				route = $urandom_range(0, 2);
			a = random_coef();
			pick = $urandom_range(0, 7);
			if (pick < 2)
				b = -a;
			else if (pick == 2)
				b = a[31] ? COEF_MIN : COEF_MAX;
			else
				b = random_coef();
			w.exponent = e[15:0];
			if (route != 1) begin
				w.command = CMD_LOAD_FIRST;
				w.coefficient = a;
				first_q.push_back(w);
			end
			if (route != 0) begin
				w.command = CMD_LOAD_SECOND;
				w.coefficient = (route == 2) ? b : a;
				second_q.push_back(w);
			end
		end
		if (kind == SEQ_UNSORTED) begin
			for (k = 0; k < 2; k++) begin
				if (first_q.size() > 1) begin
					pos = $urandom_range(1, first_q.size() - 1);
					w = first_q[pos];
					first_q[pos] = first_q[0];
					first_q[0] = w;
				end
				if (second_q.size() > 1) begin
					pos = $urandom_range(1, second_q.size() - 1);
					w = second_q[pos];
					second_q[pos] = second_q[0];
					second_q[0] = w;
				end
			end
		end
		while (first_q.size() + second_q.size() > 0) begin
			if ($urandom_range(0, 15) == 0)
				put_word(CMD_SPARE, $urandom, 16'($urandom));
			if (second_q.size() == 0 || (first_q.size() != 0 && $urandom_range(0, 1)))
				send_word(first_q.pop_front());
			else
				send_word(second_q.pop_front());
		end
		if (kind != SEQ_NO_RUN)
			put_word(CMD_RUN, $urandom, 16'($urandom));
	endtask

	initial begin
		int phase;
		int target;
		int seq_count;
		int kind;
		seq_count = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		put_word(CMD_RUN, 32'sh7FFF_FFFF, 16'hFFFF);
		put_word(CMD_LOAD_FIRST, '0, 16'd0);
		put_word(CMD_LOAD_SECOND, 32'sh0001_0000, 16'd2);
		put_word(CMD_LOAD_FIRST, -32'sd1, 16'd3);
		put_word(CMD_LOAD_SECOND, 32'sd1, 16'd5);
		put_word(CMD_LOAD_FIRST, COEF_MAX, 16'd5);
		put_word(CMD_SPARE, 32'shFFFF_FFFF, 16'hFFFF);
		put_word(CMD_LOAD_FIRST, -32'sh0001_2345, 16'd7);
		put_word(CMD_LOAD_SECOND, 32'sh0001_2345, 16'd7);
		put_word(CMD_LOAD_FIRST, COEF_MIN, 16'hFFFF);
		put_word(CMD_LOAD_SECOND, -32'sd1, 16'hFFFF);
		put_word(CMD_RUN, '0, '0);
		put_word(CMD_LOAD_FIRST, 32'sd10, 16'd9);
		put_word(CMD_LOAD_FIRST, 32'sd20, 16'd3);
		put_word(CMD_LOAD_SECOND, 32'sd30, 16'd4);
		put_word(CMD_RUN, '0, '0);
		put_word(CMD_LOAD_SECOND, COEF_MIN, 16'd100);
		put_word(CMD_LOAD_FIRST, COEF_MIN, 16'd100);
		put_word(CMD_RUN, '0, '0);
		wait_drained();

		for (phase = 0; phase < 3; phase++) begin
			send_idle_pct = (phase == 0) ? 20 : (phase == 1) ? 73 : 0;
			recv_idle_pct <= (phase == 0) ? 73 : (phase == 1) ? 20 : 0;
			target = sent_items + PHASE_ITEMS;
			while (sent_items < target) begin
				if (seq_count == 0)
					kind = SEQ_FULL;
				else if (seq_count == 1)
					kind = SEQ_OVERFLOW;
				else
					kind = $urandom_range(0, SEQ_KINDS - 1);
				send_polynomials(kind);
				seq_count++;
			end
			put_word(CMD_RUN, $urandom, 16'($urandom));
			wait_drained();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("run: %0d words sent in %0d add runs, %0d result words checked",
			sent_items, runs, checked);
		$display("run: empty, saturated, cancelled, unsorted, full and overflowing lists");
		if (mismatches == 0 && pending == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
